// ===== hdl/sld_pkg.sv =====
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package sld_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_INDEX_W = 1;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_VALUE      = 1'b0,
      CSR_MAX_PAYLOAD_LEN = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   localparam byte_type SYNC_VALUE_RESET      = 8'd170;
   localparam byte_type MAX_PAYLOAD_LEN_RESET = 8'd169;

endpackage

`default_nettype wire

// ===== hdl/sld_req_if.sv =====
// Input channel: one received byte per transfer, valid/ready handshake.
// Depends on sld_pkg.
`default_nettype none

interface sld_req_if;

   logic              valid;
   logic              ready;
   sld_pkg::byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// ===== hdl/sld_rsp_if.sv =====
// Result channel: payload bytes and end-of-packet verdicts, valid/ready handshake.
// Depends on sld_pkg.
`default_nettype none

interface sld_rsp_if;

   logic              valid;
   logic              ready;
   sld_pkg::kind_type kind;
   sld_pkg::byte_type data;
   sld_pkg::byte_type byte_index;
   logic              checksum_ok;

   modport source (output valid, output kind, output data, output byte_index,
                   output checksum_ok, input ready);
   modport sink   (input valid, input kind, input data, input byte_index,
                   input checksum_ok, output ready);

endinterface

`default_nettype wire

// ===== hdl/sync_length_checksum_deframer_unit.sv =====
// Deframer for packets of the form sync, sync, length, payload, checksum.
// Uses sld_pkg, sld_req_if and sld_rsp_if.
//
// Every received byte passes through an input register and then frame
// tracking; payload and checksum bytes go on into the result register, and
// one byte is taken per cycle while the result side keeps up; a stalled
// result holds both stages. Each payload byte comes out with its
// index; the byte after the payload yields an end-of-packet result carrying
// the received checksum and whether it equals the inverted 8-bit payload sum.
// Lengths above max_payload_len drop the frame and hunting restarts.
`default_nettype none

module sync_length_checksum_deframer_unit (
   input  wire                        clock,
   input  wire                        reset,
   sld_req_if.sink                    req_chan,
   sld_rsp_if.source                  rsp_chan,
   input  wire                        csr_we,
   input  wire sld_pkg::csr_index_type csr_index,
   input  wire sld_pkg::byte_type     csr_wdata
);

   typedef enum logic [2:0] {
      PH_HUNT1 = 3'd0,
      PH_HUNT2 = 3'd1,
      PH_LEN   = 3'd2,
      PH_DATA  = 3'd3,
      PH_CSUM  = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in;
   sld_pkg::byte_type sync_value_ff, sync_value_in;
   sld_pkg::byte_type max_len_ff, max_len_in;
   sld_pkg::byte_type remaining_ff, remaining_in;
   sld_pkg::byte_type position_ff, position_in;
   sld_pkg::byte_type sum_ff, sum_in;

   logic              in_valid_ff, in_valid_in;
   sld_pkg::byte_type in_byte_ff, in_byte_in;

   logic              out_valid_ff, out_valid_in;
   sld_pkg::kind_type out_kind_ff, out_kind_in;
   sld_pkg::byte_type out_data_ff, out_data_in;
   sld_pkg::byte_type out_index_ff, out_index_in;
   logic              out_ok_ff, out_ok_in;

   logic              advance;
   logic              consume;
   logic              csum_match;

   assign advance    = !out_valid_ff || rsp_chan.ready;
   assign consume    = in_valid_ff && advance;
   assign csum_match = (~sum_ff) == in_byte_ff;

   assign req_chan.ready       = !in_valid_ff || advance;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.kind        = out_kind_ff;
   assign rsp_chan.data        = out_data_ff;
   assign rsp_chan.byte_index  = out_index_ff;
   assign rsp_chan.checksum_ok = out_ok_ff;

   always_comb begin
      sync_value_in = sync_value_ff;
      max_len_in    = max_len_ff;
      if (csr_we) begin
         case (csr_index)
            sld_pkg::CSR_SYNC_VALUE:      sync_value_in = csr_wdata;
            sld_pkg::CSR_MAX_PAYLOAD_LEN: max_len_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         if (req_chan.valid) begin
            in_byte_in = req_chan.rx_byte;
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_index_in = out_index_ff;
      out_ok_in    = out_ok_ff;
      if (advance) begin
         out_valid_in = 1'b0;
      end
      if (consume) begin
         case (phase_ff)
            PH_HUNT2: begin
               phase_in = (in_byte_ff == sync_value_ff) ? PH_LEN : PH_HUNT1;
            end
            PH_LEN: begin
               if (in_byte_ff != sync_value_ff) begin
                  if (in_byte_ff > max_len_ff) begin
                     phase_in = PH_HUNT1;
                  end else begin
                     remaining_in = in_byte_ff;
                     position_in  = '0;
                     sum_in       = '0;
                     phase_in     = (in_byte_ff == '0) ? PH_CSUM : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               out_valid_in = 1'b1;
               out_kind_in  = sld_pkg::KIND_PAYLOAD;
               out_data_in  = in_byte_ff;
               out_index_in = position_ff;
               out_ok_in    = 1'b0;
               sum_in       = sum_ff + in_byte_ff;
               position_in  = position_ff + 8'd1;
               remaining_in = remaining_ff - 8'd1;
               if (remaining_ff == 8'd1) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               out_valid_in = 1'b1;
               out_kind_in  = sld_pkg::KIND_END;
               out_data_in  = in_byte_ff;
               out_index_in = '0;
               out_ok_in    = csum_match;
               if (csum_match) begin
                  phase_in = PH_HUNT1;
               end else begin
                  phase_in = (in_byte_ff == sync_value_ff) ? PH_HUNT2 : PH_HUNT1;
               end
            end
            default: begin
               phase_in = (in_byte_ff == sync_value_ff) ? PH_HUNT2 : PH_HUNT1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT1;
         sync_value_ff <= sld_pkg::SYNC_VALUE_RESET;
         max_len_ff    <= sld_pkg::MAX_PAYLOAD_LEN_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         sync_value_ff <= sync_value_in;
         max_len_ff    <= max_len_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      remaining_ff <= remaining_in;
      position_ff  <= position_in;
      sum_ff       <= sum_in;
      in_byte_ff   <= in_byte_in;
      out_kind_ff  <= out_kind_in;
      out_data_ff  <= out_data_in;
      out_index_ff <= out_index_in;
      out_ok_ff    <= out_ok_in;
   end

   a_reset_hunts: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_HUNT1 && !in_valid_ff && !out_valid_ff))
      else $error("phase or valid not cleared by reset");

   a_data_has_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remaining_ff != '0))
      else $error("payload phase with nothing remaining");

   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      (consume && (phase_ff == PH_DATA || phase_ff == PH_CSUM)) |=> out_valid_ff)
      else $error("payload or checksum byte produced no result");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == sld_pkg::KIND_END) |-> (out_index_ff == '0))
      else $error("end-of-packet result with nonzero index");

   a_payload_not_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == sld_pkg::KIND_PAYLOAD) |-> !out_ok_ff)
      else $error("payload result flagged checksum_ok");

endmodule

`default_nettype wire
